FILE: design/sml_pkg.sv
package sml_pkg;

   localparam int MAX_DIMS   = 4;
   localparam int SIZE_BITS  = 24;
   localparam int DIM_FIELDS = 4;
   localparam int DIM_LIMIT  = (MAX_DIMS < DIM_FIELDS) ? MAX_DIMS : DIM_FIELDS;
   localparam int DIM_IDX_W  = 2;
   localparam int ND_W       = 3;
   localparam int DIM_W      = 16;
   localparam int ESZ_W      = 12;
   localparam int BW_W       = 7;
   localparam int OFF_W      = SIZE_BITS + 1;
   localparam int BITS_W     = SIZE_BITS + 3;
   localparam int PROD_W     = ESZ_W + SIZE_BITS;
   localparam int MUL_W      = SIZE_BITS + DIM_W;
   localparam int UNIT_W     = ESZ_W + 3;
   localparam int OUT_W      = 24;
   localparam int BOFF_W     = 6;

   localparam logic [OFF_W-1:0] ALIGN_M2 = OFF_W'(32'h1);
   localparam logic [OFF_W-1:0] ALIGN_M4 = OFF_W'(32'h3);
   localparam logic [OFF_W-1:0] ALIGN_M8 = OFF_W'(32'h7);

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CLOSE = 1'b1;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_NEG  = 2'd1;
   localparam logic [1:0] ERR_OVF  = 2'd2;

   typedef struct packed {
      logic                    opcode;
      logic [ESZ_W-1:0]        elem_size;
      logic [BW_W-1:0]         bit_width;
      logic [ND_W-1:0]         dim_count;
      logic signed [DIM_W-1:0] dim_0;
      logic signed [DIM_W-1:0] dim_1;
      logic signed [DIM_W-1:0] dim_2;
      logic signed [DIM_W-1:0] dim_3;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0]  member_offset;
      logic [BOFF_W-1:0] member_bit_offset;
      logic [OUT_W-1:0]  element_count;
      logic [OUT_W-1:0]  record_size;
      logic              is_total;
      logic [1:0]        error_code;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_MUL,
      ST_PROD,
      ST_PLACE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                 load;
      logic                 align;
      logic                 mul;
      logic [DIM_IDX_W-1:0] dim_idx;
      logic                 prod;
      logic                 place;
      logic                 emit;
   } dp_cmd_type;

   typedef struct packed {
      logic [ND_W-1:0] dim_num;
      logic            out_free;
   } dp_sts_type;

   // Round pos up by the size class of sz.
   function automatic logic [OFF_W-1:0] align_up(input logic [SIZE_BITS-1:0] pos,
                                                 input logic [SIZE_BITS-1:0] sz);
      logic [OFF_W-1:0] p;
      p = {1'b0, pos};
      if (sz == SIZE_BITS'(1)) begin
         return p;
      end else if (sz == SIZE_BITS'(2)) begin
         return (p + ALIGN_M2) & ~ALIGN_M2;
      end else if (sz inside {SIZE_BITS'(3), SIZE_BITS'(4)}) begin
         return (p + ALIGN_M4) & ~ALIGN_M4;
      end else begin
         return (p + ALIGN_M8) & ~ALIGN_M8;
      end
   endfunction

endpackage

FILE: design/sml_ctrl.sv
module sml_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sml_pkg::dp_sts_type sts,
   output sml_pkg::dp_cmd_type cmd
);
   import sml_pkg::*;

   state_type            state_ff, state_in;
   logic [DIM_IDX_W-1:0] idx_ff, idx_in;
   logic [ND_W-1:0]      idx_next;

   assign idx_next = ND_W'(idx_ff) + ND_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.dim_idx = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            cmd.align = 1'b1;
            state_in  = (sts.dim_num == '0) ? ST_PROD : ST_MUL;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            // advance one dimension per cycle until the clamped count is used up
            if (idx_next == sts.dim_num) begin
               state_in = ST_PROD;
            end else begin
               idx_in = idx_next[DIM_IDX_W-1:0];
            end
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_PLACE;
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register can take the result
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: design/sml_dp.sv
module sml_dp (
   input  logic                clock,
   input  logic                reset,
   input  sml_pkg::req_type    req_data,
   input  sml_pkg::dp_cmd_type cmd,
   output sml_pkg::dp_sts_type sts,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sml_pkg::rsp_type    rsp_data
);
   import sml_pkg::*;

   req_type               req_ff;
   logic [SIZE_BITS-1:0]  run_bytes_ff, run_bytes_in;
   logic [BITS_W-1:0]     run_bits_ff, run_bits_in;
   logic [1:0]            sticky_ff, sticky_in;
   logic [OFF_W-1:0]      off_ff;
   logic [SIZE_BITS-1:0]  cnt_ff;
   logic                  ovf_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [BITS_W:0]       bf_bits_ff;
   logic [UNIT_W-1:0]     bf_used_ff;
   rsp_type               rslt_ff, rslt_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic [DIM_W-1:0]      dim_arr [DIM_FIELDS];
   logic [ND_W-1:0]       dim_num;
   logic                  neg;
   logic [MUL_W-1:0]      mul_prod;
   logic [SIZE_BITS-1:0]  esz_ext;

   logic [UNIT_W-1:0]     unit, unit_m1, used_raw, rest;
   logic                  skip;

   logic                  is_bf;
   logic [ESZ_W-1:0]      esz_m1;
   logic [OFF_W-1:0]      off_bf, off_sel;
   logic [OFF_W:0]        off_end, nsize_bf;
   logic [BITS_W+1:0]     nbits;
   logic                  bf_ovf;
   logic [PROD_W:0]       nsize_arr;
   logic                  arr_ovf;
   logic [OFF_W-1:0]      close_size;

   assign dim_arr[0] = req_ff.dim_0;
   assign dim_arr[1] = req_ff.dim_1;
   assign dim_arr[2] = req_ff.dim_2;
   assign dim_arr[3] = req_ff.dim_3;

   assign dim_num = (req_ff.dim_count > ND_W'(DIM_LIMIT)) ? ND_W'(DIM_LIMIT)
                                                          : req_ff.dim_count;
   assign esz_ext = SIZE_BITS'(req_ff.elem_size);

   always_comb begin
      neg = 1'b0;
      for (int i = 0; i < DIM_FIELDS; i++) begin
         if (ND_W'(i) < dim_num && dim_arr[i][DIM_W-1]) begin
            neg = 1'b1;
         end
      end
   end

   assign mul_prod = MUL_W'(cnt_ff) * MUL_W'(dim_arr[cmd.dim_idx]);

   // bitfield unit fit, prepared ahead of placement
   assign unit     = {req_ff.elem_size, 3'b000};
   assign unit_m1  = unit - UNIT_W'(1);
   assign used_raw = run_bits_ff[UNIT_W-1:0] & unit_m1;
   assign rest     = unit - used_raw;
   assign skip     = rest < UNIT_W'(req_ff.bit_width);

   assign is_bf    = (req_ff.bit_width != '0) && (req_ff.elem_size != '0);
   assign esz_m1   = req_ff.elem_size - ESZ_W'(1);
   assign off_bf   = bf_bits_ff[BITS_W:3] & ~OFF_W'(esz_m1);
   assign off_sel  = is_bf ? off_bf : off_ff;
   assign off_end  = {1'b0, off_sel} + (OFF_W+1)'(req_ff.elem_size);
   assign nsize_bf = ((OFF_W+1)'(run_bytes_ff) < off_end) ? off_end
                                                          : (OFF_W+1)'(run_bytes_ff);
   assign nbits    = is_bf ? ((BITS_W+2)'({off_bf, 3'b000}) + (BITS_W+2)'(bf_used_ff)
                              + (BITS_W+2)'(req_ff.bit_width))
                           : {off_end, 3'b000};
   assign bf_ovf   = (|nsize_bf[OFF_W:SIZE_BITS]) || (|nbits[BITS_W+1:BITS_W]);

   assign nsize_arr = (PROD_W+1)'(off_ff) + (PROD_W+1)'(prod_ff);
   assign arr_ovf   = ovf_ff || (|nsize_arr[PROD_W:SIZE_BITS]);

   assign close_size = align_up(run_bytes_ff, run_bytes_ff);

   always_comb begin
      rslt_in      = '0;
      run_bytes_in = run_bytes_ff;
      run_bits_in  = run_bits_ff;
      sticky_in    = sticky_ff;
      if (req_ff.opcode == OP_CLOSE) begin
         rslt_in.is_total = 1'b1;
         if (sticky_ff != ERR_NONE) begin
            rslt_in.error_code = sticky_ff;
         end else if (close_size[SIZE_BITS]) begin
            rslt_in.error_code = ERR_OVF;
         end else begin
            rslt_in.record_size = OUT_W'(close_size[SIZE_BITS-1:0]);
         end
         run_bytes_in = '0;
         run_bits_in  = '0;
         sticky_in    = ERR_NONE;
      end else if (sticky_ff != ERR_NONE) begin
         rslt_in.error_code = sticky_ff;
      end else if (off_ff[SIZE_BITS]) begin
         rslt_in.error_code = ERR_OVF;
         sticky_in          = ERR_OVF;
      end else if (dim_num != '0) begin
         if (neg) begin
            rslt_in.error_code = ERR_NEG;
            sticky_in          = ERR_NEG;
         end else if (arr_ovf) begin
            rslt_in.error_code = ERR_OVF;
            sticky_in          = ERR_OVF;
         end else begin
            run_bytes_in            = nsize_arr[SIZE_BITS-1:0];
            run_bits_in             = {nsize_arr[SIZE_BITS-1:0], 3'b000};
            rslt_in.member_offset   = OUT_W'(off_ff[SIZE_BITS-1:0]);
            rslt_in.element_count   = OUT_W'(cnt_ff);
         end
      end else begin
         if (bf_ovf) begin
            rslt_in.error_code = ERR_OVF;
            sticky_in          = ERR_OVF;
         end else begin
            run_bytes_in              = nsize_bf[SIZE_BITS-1:0];
            run_bits_in               = nbits[BITS_W-1:0];
            rslt_in.member_offset     = OUT_W'(off_sel[SIZE_BITS-1:0]);
            rslt_in.member_bit_offset = is_bf ? bf_used_ff[BOFF_W-1:0] : '0;
            rslt_in.element_count     = OUT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_bytes_ff <= '0;
         run_bits_ff  <= '0;
         sticky_ff    <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.place) begin
            run_bytes_ff <= run_bytes_in;
            run_bits_ff  <= run_bits_in;
            sticky_ff    <= sticky_in;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
         cnt_ff <= SIZE_BITS'(1);
         ovf_ff <= 1'b0;
      end else if (cmd.mul) begin
         cnt_ff <= mul_prod[SIZE_BITS-1:0];
         ovf_ff <= ovf_ff | (|mul_prod[MUL_W-1:SIZE_BITS]);
      end
      if (cmd.align) begin
         off_ff <= align_up(run_bytes_ff, esz_ext);
      end
      if (cmd.prod) begin
         prod_ff    <= PROD_W'(req_ff.elem_size) * PROD_W'(cnt_ff);
         bf_bits_ff <= {1'b0, run_bits_ff} + (skip ? (BITS_W+1)'(rest) : '0);
         bf_used_ff <= skip ? '0 : used_raw;
      end
      if (cmd.place) begin
         rslt_ff <= rslt_in;
      end
      if (cmd.emit) begin
         rsp_data_ff <= rslt_ff;
      end
   end

   assign sts.dim_num  = dim_num;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an unread result");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.place && req_ff.opcode == OP_CLOSE) |=>
         (run_bytes_ff == '0 && run_bits_ff == '0 && sticky_ff == ERR_NONE))
      else $error("close did not clear layout state");

   a_sticky_code: assert property (@(posedge clock) disable iff (reset)
      sticky_ff == ERR_NONE || sticky_ff == ERR_NEG || sticky_ff == ERR_OVF)
      else $error("bad sticky error code");

   a_total_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.is_total) |->
         (rsp_data_ff.member_offset == '0 && rsp_data_ff.element_count == '0))
      else $error("close result carries member fields");

   a_error_no_place: assert property (@(posedge clock) disable iff (reset)
      (cmd.place && req_ff.opcode == OP_ADD && sticky_ff != ERR_NONE) |=>
         $stable(run_bytes_ff))
      else $error("member placed under sticky error");

endmodule

FILE: design/struct_member_layout_core.sv
// Record layout engine: places members of a C-style record one request at a time.
// Request channel (req_valid/req_ready/req_data): opcode add places a member,
// aligned by its size class, extended by its array dimensions or packed as a bitfield;
// opcode close rounds the running size, reports it and clears the record.
// Response channel (rsp_valid/rsp_ready/rsp_data): exactly one result per request,
// in request order, carrying offset, bit offset, element count or total and error.
// Steps: the request is accepted and loaded, then aligned; each array dimension used
// (0 to 4) then takes one pass through the shared 24x16 multiplier; the element-size
// multiply, placement and the load of the output register follow in that order.
// A new request is taken only after the previous one has reached the output register.
// The result sits in an output register, so the next request is taken while the
// previous response still waits; a stalled receiver holds the engine only once
// the following result is ready to be loaded.
// Errors (negative dimension, size overflow) are sticky until the next close.
// Reset (synchronous) clears running size, bit count, error and the response valid.
module struct_member_layout_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sml_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sml_pkg::rsp_type rsp_data
);
   import sml_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   sml_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sml_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: test/struct_member_layout_core_tb.sv
`timescale 1ns / 100ps

module struct_member_layout_core_tb;
   import sml_pkg::*;

   localparam longint unsigned SIZE_LIMIT = (64'd1 << SIZE_BITS) - 64'd1;
   localparam longint unsigned BITS_LIMIT = (64'd1 << (SIZE_BITS + 3)) - 64'd1;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // layout state of the record being built
   longint unsigned rec_bytes = 0;
   longint unsigned rec_bits  = 0;
   logic [1:0]      rec_error = ERR_NONE;

   rsp_type expected_layout[$];

   bit idle_enable  = 1'b1;
   bit stall_enable = 1'b1;
   int stall_left   = 0;

   int unsigned requests_sent   = 0;
   int unsigned results_checked = 0;
   int unsigned totals_seen     = 0;
   int unsigned error_results   = 0;
   int unsigned mismatch_count  = 0;

   struct_member_layout_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   function automatic longint unsigned round_to_class(longint unsigned pos,
                                                      longint unsigned sz);
      if (sz == 1) begin
         return pos;
      end else if (sz == 2) begin
         return (pos + 64'h1) & ~64'h1;
      end else if (sz == 3 || sz == 4) begin
         return (pos + 64'h3) & ~64'h3;
      end else begin
         return (pos + 64'h7) & ~64'h7;
      end
   endfunction

   // Place one member (or close the record) and return the layout result.
   function automatic rsp_type place_member(req_type r);
      rsp_type                 res;
      longint unsigned         esz, bw, nd, off, boff, cnt, nsize, nbits;
      longint unsigned         unit, bits, used, rest, rnd;
      logic signed [DIM_W-1:0] dv [4];
      logic [1:0]              err;
      bit                      ovf;
      res  = '0;
      esz  = 64'(r.elem_size);
      bw   = 64'(r.bit_width);
      nd   = 64'(r.dim_count);
      dv[0] = r.dim_0;
      dv[1] = r.dim_1;
      dv[2] = r.dim_2;
      dv[3] = r.dim_3;
      boff = 0;
      cnt  = 1;
      if (r.opcode == OP_CLOSE) begin
         rnd = round_to_class(rec_bytes, rec_bytes);
         err = rec_error;
         if (err == ERR_NONE && rnd > SIZE_LIMIT) err = ERR_OVF;
         res.is_total    = 1'b1;
         res.error_code  = err;
         res.record_size = (err == ERR_NONE) ? rnd[OUT_W-1:0] : '0;
         rec_bytes = 0;
         rec_bits  = 0;
         rec_error = ERR_NONE;
         return res;
      end
      if (rec_error != ERR_NONE) begin
         res.error_code = rec_error;
         return res;
      end
      if (nd > 64'(MAX_DIMS)) nd = 64'(MAX_DIMS);
      if (nd > 4) nd = 4;
      off = round_to_class(rec_bytes, esz);
      if (off > SIZE_LIMIT) begin
         rec_error = ERR_OVF;
         res.error_code = ERR_OVF;
         return res;
      end
      if (nd > 0) begin
         for (int k = 0; k < nd; k++) begin
            if (dv[k] < 0) begin
               rec_error = ERR_NEG;
               res.error_code = ERR_NEG;
               return res;
            end
         end
         ovf = 1'b0;
         for (int k = 0; k < nd; k++) begin
            cnt = cnt * {48'b0, dv[k]};
            if (cnt > SIZE_LIMIT) begin
               ovf = 1'b1;
               cnt = SIZE_LIMIT + 1;
            end
         end
         nsize = ovf ? SIZE_LIMIT + 1 : off + esz * cnt;
         if (nsize > SIZE_LIMIT) begin
            rec_error = ERR_OVF;
            res.error_code = ERR_OVF;
            return res;
         end
         nbits = nsize << 3;
      end else begin
         if (bw > 0 && esz > 0) begin
            unit = esz << 3;
            bits = rec_bits;
            used = bits & (unit - 1);
            rest = unit - used;
            // skip to the next unit when the rest is too short
            if (rest < bw) begin
               bits = bits + rest;
               used = 0;
            end
            off   = (bits >> 3) & ~(esz - 1);
            boff  = used;
            nbits = (off << 3) + used + bw;
         end else begin
            nbits = (off + esz) << 3;
         end
         nsize = (rec_bytes < off + esz) ? off + esz : rec_bytes;
         if (nsize > SIZE_LIMIT || nbits > BITS_LIMIT) begin
            rec_error = ERR_OVF;
            res.error_code = ERR_OVF;
            return res;
         end
      end
      rec_bytes = nsize;
      rec_bits  = nbits;
      res.member_offset     = off[OUT_W-1:0];
      res.member_bit_offset = boff[BOFF_W-1:0];
      res.element_count     = cnt[OUT_W-1:0];
      return res;
   endfunction

   function automatic req_type random_request();
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic req_type make_member(input int esz, bw, nd, d0, d1, d2, d3);
      req_type r;
      r.opcode    = OP_ADD;
      r.elem_size = ESZ_W'(esz);
      r.bit_width = BW_W'(bw);
      r.dim_count = ND_W'(nd);
      r.dim_0     = DIM_W'(d0);
      r.dim_1     = DIM_W'(d1);
      r.dim_2     = DIM_W'(d2);
      r.dim_3     = DIM_W'(d3);
      return r;
   endfunction

   function automatic req_type make_close();
      req_type r;
      r = random_request();
      r.opcode = OP_CLOSE;
      return r;
   endfunction

   function automatic int pick_size();
      case ($urandom_range(0, 9))
         0: return 1;
         1: return 2;
         2: return 4;
         3: return 8;
         4: return 3;
         5: return 0;
         6: return $urandom_range(5, 16);
         7: return 16;
         8: return $urandom_range(0, 4095);
         default: return $urandom_range(1, 8);
      endcase
   endfunction

   // Mostly well-formed members: scalars, bitfields, arrays, rare errors.
   function automatic req_type random_member();
      req_type r;
      int      sel, esz, bw, nd, used, bad;
      int      dims [4];
      r = random_request();
      r.opcode = OP_ADD;
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         esz = pick_size();
         r.elem_size = ESZ_W'(esz);
         r.bit_width = '0;
         r.dim_count = '0;
      end else if (sel < 60) begin
         case ($urandom_range(0, 7))
            0, 1:    esz = 1;
            2:       esz = 2;
            3, 4:    esz = 4;
            5:       esz = 8;
            default: esz = pick_size();
         endcase
         if (esz == 0 || $urandom_range(0, 19) == 0) begin
            bw = $urandom_range(1, 127);
         end else begin
            bw = $urandom_range(1, (esz >= 8) ? 64 : 8 * esz);
         end
         r.elem_size = ESZ_W'(esz);
         r.bit_width = BW_W'(bw);
         r.dim_count = '0;
      end else begin
         nd   = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
         used = (nd > 4) ? 4 : nd;
         esz  = pick_size();
         for (int k = 0; k < 4; k++) begin
            if (k >= used) begin
               dims[k] = $urandom_range(0, 65535);
            end else if ($urandom_range(0, 7) == 0) begin
               dims[k] = $urandom_range(0, 300);
            end else begin
               dims[k] = $urandom_range(0, 8);
            end
         end
         if (sel >= 95) begin
            dims[$urandom_range(0, used - 1)] = $urandom_range(1000, 32767);
         end else if (sel >= 90) begin
            bad = $urandom_range(0, used - 1);
            dims[bad] = -int'($urandom_range(1, 32768));
         end
         r.elem_size = ESZ_W'(esz);
         r.dim_count = ND_W'(nd);
         r.dim_0     = DIM_W'(dims[0]);
         r.dim_1     = DIM_W'(dims[1]);
         r.dim_2     = DIM_W'(dims[2]);
         r.dim_3     = DIM_W'(dims[3]);
      end
      return r;
   endfunction

   // Called at a rising edge; leaves valid high after acceptance.
   task automatic send_request(input req_type item);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      expected_layout.push_back(place_member(item));
      requests_sent++;
   endtask

   task automatic wait_results_done();
      req_valid <= 1'b0;
      while (expected_layout.size() != 0) @(posedge clock);
   endtask

   task automatic test_alignment();
      send_request(make_close());
      send_request(make_member(1, 0, 0, 0, 0, 0, 0));
      send_request(make_member(2, 0, 0, 0, 0, 0, 0));
      send_request(make_member(3, 0, 0, 0, 0, 0, 0));
      send_request(make_member(0, 0, 0, 0, 0, 0, 0));
      send_request(make_member(4095, 0, 0, 0, 0, 0, 0));
      send_request(make_close());
      wait_results_done();
   endtask

   task automatic test_arrays();
      // unused dimensions must not matter, even when negative
      send_request(make_member(4, 5, 2, 3, 5, 7, -1));
      send_request(make_member(2, 0, 7, 2, 2, 2, 2));
      send_request(make_member(8, 0, 1, 0, 9, 9, 9));
      send_request(make_member(1, 0, 2, 32767, -32768, 0, 0));
      send_request(make_member(1, 0, 0, 0, 0, 0, 0));
      send_request(make_close());
      wait_results_done();
   endtask

   task automatic test_bitfields();
      send_request(make_member(4, 3, 0, 0, 0, 0, 0));
      send_request(make_member(4, 30, 0, 0, 0, 0, 0));
      send_request(make_member(0, 5, 0, 0, 0, 0, 0));
      send_request(make_member(3, 7, 0, 0, 0, 0, 0));
      send_request(make_member(1, 12, 0, 0, 0, 0, 0));
      send_request(make_member(8, 64, 0, 0, 0, 0, 0));
      send_request(make_close());
      wait_results_done();
   endtask

   task automatic test_overflow();
      // fill to exactly the top of the range, then let the close round past it
      send_request(make_member(4095, 0, 2, 4097, 1, 0, 0));
      send_request(make_close());
      send_request(make_member(1, 0, 2, 32767, 32767, 0, 0));
      send_request(make_close());
      wait_results_done();
   endtask

   task automatic test_random_records(input int count, input bit allow_idle);
      int sent, members;
      sent = 0;
      while (sent < count) begin
         idle_enable  = allow_idle && ($urandom_range(0, 3) != 0);
         stall_enable = allow_idle && ($urandom_range(0, 3) != 0);
         members = $urandom_range(1, 10);
         for (int k = 0; k < members; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_request(random_request());
            end else begin
               send_request(random_member());
            end
            sent++;
         end
         send_request(make_close());
         sent++;
         if (allow_idle && $urandom_range(0, 9) == 0) wait_results_done();
      end
   endtask

   // Receiver: drops ready in random stall bursts.
   always @(posedge clock) begin
      if (reset || !stall_enable) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 15);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic void check_field(string name, logic [OUT_W-1:0] want,
                                       logic [OUT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_layout.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = expected_layout.pop_front();
            results_checked++;
            if (want.is_total) totals_seen++;
            if (want.error_code != ERR_NONE) error_results++;
            check_field("member_offset", want.member_offset, rsp_data.member_offset);
            check_field("member_bit_offset", OUT_W'(want.member_bit_offset),
                        OUT_W'(rsp_data.member_bit_offset));
            check_field("element_count", want.element_count, rsp_data.element_count);
            check_field("record_size", want.record_size, rsp_data.record_size);
            check_field("is_total", OUT_W'(want.is_total), OUT_W'(rsp_data.is_total));
            check_field("error_code", OUT_W'(want.error_code),
                        OUT_W'(rsp_data.error_code));
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_alignment();
      test_arrays();
      test_bitfields();
      test_overflow();
      test_random_records(600, 1'b1);
      // last stretch: no idling on either side
      test_random_records(100, 1'b0);
      wait_results_done();
      repeat (30) @(posedge clock);
      $display("covered %0d requests and checked %0d results: %0d record closes, %0d errors",
               requests_sent, results_checked, totals_seen, error_results);
      if (mismatch_count == 0 && expected_layout.size() == 0) begin
         $display("struct_member_layout_core_tb OK");
      end else begin
         $display("struct_member_layout_core_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("struct_member_layout_core_tb NOT OK");
      $finish;
   end

endmodule

FILE: filelist.f
design/sml_pkg.sv
design/sml_ctrl.sv
design/sml_dp.sv
design/struct_member_layout_core.sv
test/struct_member_layout_core_tb.sv
